// ===== src/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants for the positional list stack
// Command and status codes, the cell command struct and the default depth.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int VAL_W         = 32;
  localparam int POS_W         = 5;
  localparam int CNT_OUT_W     = 5;
  localparam logic [VAL_W-1:0] MOST_NEG = 32'h8000_0000;

  // Request command codes
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_REMOVE_AT  = 3'd5,
    CMD_READ_FRONT = 3'd6,
    CMD_READ_ALL   = 3'd7
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Per-cycle operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_REM  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [VAL_W-1:0]  value;
  } cell_cmd_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

endpackage

`default_nettype wire

// ===== src/pls_cell.sv =====
// ----------------------------------------------------------------------------
// pls_cell: one list slot
// Holds one entry and each cycle keeps it, loads the new value, takes the
// entry of its front-side or back-side neighbor, or, as the tail on rotate, slot 0.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_cell
  import pls_pkg::*;
#(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  wire logic             clk,
  input  wire cell_cmd_t        cmd,
  input  wire logic [IW-1:0]    idx,     // affected slot for insert/remove
  input  wire logic [IW-1:0]    tail,    // last occupied slot, for rotate
  input  wire logic [VAL_W-1:0] left_i,  // neighbor toward the front
  input  wire logic [VAL_W-1:0] right_i, // neighbor toward the back
  input  wire logic [VAL_W-1:0] front_i, // slot 0, wraps to the tail on rotate
  output logic      [VAL_W-1:0] data_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  // Next entry selection
  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      OP_INS: begin
        if (MY_IDX == idx) data_nxt = cmd.value;
        else if (MY_IDX > idx) data_nxt = left_i;
      end
      OP_REM: begin
        if (MY_IDX >= idx) data_nxt = right_i;
      end
      OP_ROT: begin
        if (MY_IDX == tail) data_nxt = front_i;
        else if (MY_IDX < tail) data_nxt = right_i;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

`default_nettype wire

// ===== src/positional_list_stack_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_stack_core: bounded ordered list with positional edits
// A list of up to DEPTH signed 32-bit entries held in a chain of cells,
// slot 0 being the front (stack top).
//
// Usage:
//   in_*  : one request per transfer (command, position, value).
//   out_* : results; out_tlast marks the final result of a request.
//   Every request but read-all gives one result, registered on acceptance; a
//   new request is taken every cycle while the output register is free or
//   being drained. Insert and remove shift all cells in parallel in the
//   cycle that accepts the request.
//   Read-all of N entries gives N results, one per cycle while the receiver
//   takes them, by rotating the chain toward the front; input is held off
//   until the last result is registered. The chain is back in order once the
//   last result is issued. An empty read-all gives one result.
//   Reset clears the entry count and the output valid flag; cell contents are
//   not reset and are never read before written.
//   When the receiver holds out_tready low the result stays in the output
//   register, in_tready drops and the chain holds still.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_stack_core
  import pls_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: command[2:0], position[7:3], value[39:8]
  input  wire logic [39:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: read_value[31:0], status[33:32], entry_count[38:34], pad[39]
  output logic      [39:0] out_tdata,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // Request fields
  cmd_t               in_cmd;
  logic [POS_W-1:0]   in_pos;
  logic [VAL_W-1:0]   in_val;
  assign in_cmd = cmd_t'(in_tdata[2:0]);
  assign in_pos = in_tdata[7:3];
  assign in_val = in_tdata[39:8];

  // State
  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [38:0]      out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic             slot_free;
  logic             in_fire;
  logic [EW-1:0]    pos_e, cnt_e, pos_m1;
  logic [CW-1:0]    count_m1;
  logic             is_full, is_empty;

  // Decoded request
  logic             dec_ins, dec_rem, dec_dump;
  logic [IW-1:0]    dec_idx;
  logic [VAL_W-1:0] dec_rv;
  status_t          dec_st;

  // Chain control
  cell_cmd_t        cell_cmd;
  logic [IW-1:0]    cell_idx;
  logic [IW-1:0]    cell_tail;
  logic [VAL_W-1:0] cell_data [DEPTH];

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;

  assign pos_e    = EW'(in_pos);
  assign cnt_e    = EW'(count_r);
  assign pos_m1   = pos_e - EW'(1);
  assign count_m1 = count_r - CW'(1);
  assign is_full  = (count_r >= FULL_CNT);
  assign is_empty = (count_r == '0);

  // Request decode
  always_comb begin
    dec_ins  = 1'b0;
    dec_rem  = 1'b0;
    dec_dump = 1'b0;
    dec_idx  = '0;
    dec_rv   = '0;
    dec_st   = ST_OK;
    case (in_cmd)
      CMD_PUSH_FRONT: begin
        if (is_full) dec_st = ST_FULL;
        else dec_ins = 1'b1;
      end
      CMD_PUSH_BACK: begin
        if (is_full) dec_st = ST_FULL;
        else begin
          dec_ins = 1'b1;
          dec_idx = count_r[IW-1:0];
        end
      end
      CMD_INSERT_AT: begin
        if (pos_e == '0 || pos_e > cnt_e + EW'(1)) dec_st = ST_BADPOS;
        else if (is_full) dec_st = ST_FULL;
        else begin
          dec_ins = 1'b1;
          dec_idx = pos_m1[IW-1:0];
        end
      end
      CMD_POP_FRONT: begin
        if (is_empty) dec_st = ST_EMPTY;
        else dec_rem = 1'b1;
      end
      CMD_POP_BACK: begin
        if (is_empty) dec_st = ST_EMPTY;
        else begin
          dec_rem = 1'b1;
          dec_idx = count_m1[IW-1:0];
        end
      end
      CMD_REMOVE_AT: begin
        if (pos_e == '0 || pos_e > cnt_e) dec_st = ST_BADPOS;
        else begin
          dec_rem = 1'b1;
          dec_idx = pos_m1[IW-1:0];
        end
      end
      CMD_READ_FRONT: begin
        if (is_empty) begin
          dec_st = ST_EMPTY;
          dec_rv = MOST_NEG;
        end else begin
          dec_rv = cell_data[0];
        end
      end
      CMD_READ_ALL: begin
        if (is_empty) begin
          dec_st = ST_EMPTY;
          dec_rv = MOST_NEG;
        end else begin
          dec_dump = 1'b1;
        end
      end
      default: dec_st = ST_OK;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire && dec_dump) state_nxt = S_DUMP;
      S_DUMP: if (slot_free && rd_cnt_r == CW'(1)) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control and outputs
  always_comb begin
    count_nxt     = count_r;
    rd_cnt_nxt    = rd_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    cell_cmd.op   = OP_HOLD;
    cell_cmd.value = in_val;
    cell_idx      = dec_idx;
    cell_tail     = count_m1[IW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (dec_ins) begin
            cell_cmd.op = OP_INS;
            count_nxt   = count_r + CW'(1);
          end else if (dec_rem) begin
            cell_cmd.op = OP_REM;
            count_nxt   = count_r - CW'(1);
          end
          if (dec_dump) begin
            rd_cnt_nxt = count_r;
          end else begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            out_data_nxt  = {CNT_OUT_W'(EW'(count_nxt)), dec_st, dec_rv};
          end
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          cell_cmd.op   = OP_ROT;
          rd_cnt_nxt    = rd_cnt_r - CW'(1);
          out_valid_nxt = 1'b1;
          out_last_nxt  = (rd_cnt_r == CW'(1));
          out_data_nxt  = {CNT_OUT_W'(EW'(count_r)), ST_OK, cell_data[0]};
        end
      end
      default: cell_cmd.op = OP_HOLD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};
  assign out_tlast  = out_last_r;

  // Chain of cells, slot 0 at the front
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] left_w;
    logic [VAL_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_data[g];
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    pls_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .cmd     (cell_cmd),
      .idx     (cell_idx),
      .tail    (cell_tail),
      .left_i  (left_w),
      .right_i (right_w),
      .front_i (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

endmodule

`default_nettype wire

// ===== dv/positional_list_stack_checker.sv =====
// ----------------------------------------------------------------------------
// positional_list_stack_checker: result predictor and scoreboard for the list
// Watches both stream channels of positional_list_stack_core. Every accepted
// request updates a private copy of the list and queues the results it
// should cause; every accepted result is compared field by field with the
// oldest queued one.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_stack_checker
  import pls_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: command[2:0], position[7:3], value[39:8]
  input  wire logic [39:0] in_tdata,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  // out_tdata: read_value[31:0], status[33:32], entry_count[38:34], pad[39]
  input  wire logic [39:0] out_tdata,
  input  wire logic        out_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  output int               fail_count,
  output int               pending_results,
  output int               list_len
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [VAL_W-1:0]     read_value;
    status_t              status;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 last;
  } list_result_t;

  // Shadow copy of the list and the results still owed by the block
  logic [VAL_W-1:0] shadow_entries [DEPTH];
  int               shadow_count;
  list_result_t     owed_results [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
    list_len        = 0;
    shadow_count    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] list mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic owe_result(input logic [VAL_W-1:0] rv, input status_t st,
                            input logic last);
    list_result_t r;
    r.read_value  = rv;
    r.status      = st;
    r.entry_count = CNT_OUT_W'(shadow_count);
    r.last        = last;
    owed_results.push_back(r);
  endtask

  // Open a hole at idx, shifting the tail back by one
  task automatic shadow_insert(input int idx, input logic [VAL_W-1:0] v);
    for (int i = shadow_count; i > idx; i--)
      shadow_entries[i] = shadow_entries[i-1];
    shadow_entries[idx] = v;
    shadow_count++;
  endtask

  // Close the gap at idx, shifting the tail forward by one
  task automatic shadow_remove(input int idx);
    for (int i = idx; i + 1 < shadow_count; i++)
      shadow_entries[i] = shadow_entries[i+1];
    shadow_count--;
  endtask

  // Apply one request to the shadow list and queue what it should produce
  task automatic predict_request(input logic [39:0] req);
    cmd_t             cmd;
    int               pos;
    logic [VAL_W-1:0] val;
    status_t          st;
    logic [VAL_W-1:0] rv;
    cmd = cmd_t'(req[2:0]);
    pos = int'(req[7:3]);
    val = req[39:8];
    st  = ST_OK;
    rv  = '0;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) st = ST_FULL;
        else shadow_insert(0, val);
      end
      CMD_PUSH_BACK: begin
        if (shadow_count >= DEPTH) st = ST_FULL;
        else shadow_insert(shadow_count, val);
      end
      CMD_INSERT_AT: begin
        // bad position wins over full
        if (pos < 1 || pos > shadow_count + 1) st = ST_BADPOS;
        else if (shadow_count >= DEPTH) st = ST_FULL;
        else shadow_insert(pos - 1, val);
      end
      CMD_POP_FRONT: begin
        if (shadow_count == 0) st = ST_EMPTY;
        else shadow_remove(0);
      end
      CMD_POP_BACK: begin
        if (shadow_count == 0) st = ST_EMPTY;
        else shadow_remove(shadow_count - 1);
      end
      CMD_REMOVE_AT: begin
        if (pos < 1 || pos > shadow_count) st = ST_BADPOS;
        else shadow_remove(pos - 1);
      end
      CMD_READ_FRONT: begin
        if (shadow_count == 0) begin
          st = ST_EMPTY;
          rv = MOST_NEG;
        end else begin
          rv = shadow_entries[0];
        end
      end
      CMD_READ_ALL: begin
        if (shadow_count == 0) begin
          owe_result(MOST_NEG, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            owe_result(shadow_entries[i], ST_OK, i == shadow_count - 1);
        end
      end
      default: st = ST_OK;
    endcase
    if (cmd != CMD_READ_ALL) owe_result(rv, st, 1'b1);
  endtask

  // Compare one delivered result with the oldest owed one
  task automatic check_result();
    list_result_t         exp;
    logic [VAL_W-1:0]     got_rv;
    status_t              got_st;
    logic [CNT_OUT_W-1:0] got_cnt;
    got_rv  = out_tdata[31:0];
    got_st  = status_t'(out_tdata[33:32]);
    got_cnt = out_tdata[38:34];
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result value=%h status=%s count=%0d last=%b",
                                got_rv, got_st.name(), got_cnt, out_tlast));
    end else begin
      exp = owed_results.pop_front();
      if (got_rv !== exp.read_value)
        report_mismatch($sformatf("read_value %h, expected %h", got_rv, exp.read_value));
      if (got_st !== exp.status)
        report_mismatch($sformatf("status %s, expected %s", got_st.name(),
                                  exp.status.name()));
      if (got_cnt !== exp.entry_count)
        report_mismatch($sformatf("entry_count %0d, expected %0d", got_cnt,
                                  exp.entry_count));
      if (out_tlast !== exp.last)
        report_mismatch($sformatf("last %b, expected %b", out_tlast, exp.last));
    end
  endtask

  // Sample both channels on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      owed_results.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) predict_request(in_tdata);
    end
    pending_results = owed_results.size();
    list_len        = shadow_count;
  end

endmodule

`default_nettype wire

// ===== dv/positional_list_stack_core_tb.sv =====
// ----------------------------------------------------------------------------
// positional_list_stack_core_tb: stimulus and verdict for the list core
// Drives directed corner requests (empty, full, bad positions, every command)
// and then random request mixes that swing between growing and shrinking the
// list, with bursty input and a receiver that stalls in changing patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_stack_core_tb
  import pls_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = DEFAULT_DEPTH;
  localparam int N_RANDOM    = 320;
  localparam int HOLD_CYCLES = 120;
  localparam int TAIL_CYCLES = 24;
  localparam int CYCLE_LIMIT = 400_000;

  // Matches the in_tdata layout: command lowest, then position, then value
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
    cmd_t             command;
  } list_request_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [39:0] in_tdata   = '0;
  logic        in_tvalid  = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;

  int fail_count;
  int pending_results;
  int list_len;
  int cycle_cnt = 0;
  int burst_left = 0;
  bit hold_off_req = 1'b0;

  logic [VAL_W-1:0] corner_vals [4] = '{MOST_NEG, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};

  positional_list_stack_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  positional_list_stack_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .fail_count     (fail_count),
    .pending_results(pending_results),
    .list_len       (list_len)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("** positional_list_stack_core: FAILED **");
    $finish;
  end

  // Result receiver: stall pattern changes now and then; a long hold-off on demand
  initial begin : receiver
    int mode;
    int mode_left;
    int stall_left;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 100);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  function automatic list_request_t mk(input cmd_t cmd, input int pos,
                                       input logic [VAL_W-1:0] val);
    list_request_t r;
    r.command  = cmd;
    r.position = POS_W'(pos);
    r.value    = val;
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) == 0) return corner_vals[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // Random request, mostly well-formed positions; grow biases toward inserts
  function automatic list_request_t random_request(input int len, input bit grow);
    int   r;
    int   pos;
    cmd_t cmd;
    r   = $urandom_range(0, 99);
    pos = $urandom_range(0, 31);
    if (r < (grow ? 60 : 30)) begin
      case ($urandom_range(0, 2))
        0: cmd = CMD_PUSH_FRONT;
        1: cmd = CMD_PUSH_BACK;
        default: begin
          cmd = CMD_INSERT_AT;
          if ($urandom_range(0, 99) < 85) pos = $urandom_range(1, len + 1);
        end
      endcase
    end else if (r < 80) begin
      case ($urandom_range(0, 2))
        0: cmd = CMD_POP_FRONT;
        1: cmd = CMD_POP_BACK;
        default: begin
          cmd = CMD_REMOVE_AT;
          if (len > 0 && $urandom_range(0, 99) < 85) pos = $urandom_range(1, len);
        end
      endcase
    end else begin
      cmd = ($urandom_range(0, 1) == 0) ? CMD_READ_FRONT : CMD_READ_ALL;
    end
    return mk(cmd, pos, pick_value());
  endfunction

  // Offer one request in bursts with random gaps; returns once accepted
  task automatic offer(input list_request_t req);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, 8'($urandom)};
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    burst_left--;
    in_tdata  <= req;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering until every owed result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int i;
    int grow_left;
    bit grow;
    logic [VAL_W-1:0] v;
    grow      = 1'b1;
    grow_left = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list corners
    offer(mk(CMD_READ_FRONT, 0, 32'h0));
    offer(mk(CMD_READ_ALL, 31, 32'hFFFF_FFFF));
    offer(mk(CMD_POP_FRONT, 0, 32'h0));
    offer(mk(CMD_POP_BACK, 0, 32'h0));
    offer(mk(CMD_REMOVE_AT, 1, 32'h0));

    // Fill to capacity with every insert flavor and the value extremes
    for (i = 0; i < DEPTH; i++) begin
      v = (i < 4) ? corner_vals[i] : $urandom;
      case (i % 3)
        0: offer(mk(CMD_PUSH_FRONT, 0, v));
        1: offer(mk(CMD_PUSH_BACK, 31, v));
        default: offer(mk(CMD_INSERT_AT, $urandom_range(1, i + 1), v));
      endcase
    end

    // Full list: refused inserts, bad position preferred over full
    offer(mk(CMD_PUSH_FRONT, 0, 32'h1));
    offer(mk(CMD_PUSH_BACK, 0, 32'h2));
    offer(mk(CMD_INSERT_AT, DEPTH + 1, 32'h3));
    offer(mk(CMD_INSERT_AT, DEPTH + 2, 32'h4));
    offer(mk(CMD_READ_ALL, 0, 32'h0));

    // Removals at the ends and a bad zero position
    offer(mk(CMD_REMOVE_AT, DEPTH, 32'h0));
    offer(mk(CMD_REMOVE_AT, 0, 32'h0));
    offer(mk(CMD_POP_FRONT, 0, 32'h0));
    offer(mk(CMD_POP_BACK, 0, 32'h0));
    offer(mk(CMD_READ_FRONT, 7, 32'h0));
    wait_drained();

    // Random mix, alternating grow and shrink phases
    for (i = 0; i < N_RANDOM; i++) begin
      if (grow_left == 0) begin
        grow      = ~grow;
        grow_left = $urandom_range(25, 60);
      end
      grow_left--;
      if (i == 90) hold_off_req = 1'b1;
      if (i == 200) wait_drained();
      offer(random_request(list_len, grow));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("** positional_list_stack_core: PASSED **");
    else
      $display("** positional_list_stack_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ===== positional_list_stack_core.f =====
src/pls_pkg.sv
src/pls_cell.sv
src/positional_list_stack_core.sv
dv/positional_list_stack_checker.sv
dv/positional_list_stack_core_tb.sv
